// ===== rtl/core/thresholded_edge_degree_count_assert.svh =====
// Assertion macros used by the checker file of the degree counter.
`ifndef THRESHOLDED_EDGE_DEGREE_COUNT_ASSERT_SVH
`define THRESHOLDED_EDGE_DEGREE_COUNT_ASSERT_SVH

// Checked on every rising edge outside reset.
`define TEDC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TEDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tedc_pkg.sv =====
// Types and constants shared by the degree counter modules.
`timescale 1ns / 1ps
package tedc_pkg;

  localparam int KIND_W     = 2;
  localparam int NODE_W     = 16;
  localparam int WEIGHT_W   = 32;
  localparam int TOTAL_W    = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MASK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REG_WEIGHT_MIN  = 2'd0;
  localparam logic [1:0] REG_WEIGHT_MAX  = 2'd1;
  localparam logic [1:0] REG_MASK_ENABLE = 2'd2;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN_RST = 32'sh8000_0000;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX_RST = 32'sh7FFF_FFFF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_EVAL,
    ST_WR_A,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_min;
    logic signed [WEIGHT_W-1:0] weight_max;
    logic                       mask_enable;
  } cfg_t;

  typedef struct packed {
    logic ready;
    logic clr;
    logic rsel_b;
    logic cap_a;
    logic cap_b;
    logic wr_a;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic clear_last;
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/core/tedc_ifs.sv =====
// Request and result channel interfaces of the degree counter.
`timescale 1ns / 1ps
interface tedc_item_if import tedc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic [NODE_W-1:0]          node_a;
  logic [NODE_W-1:0]          node_b;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       mask_bit;

  modport source(output valid, kind, node_a, node_b, weight, mask_bit, input ready);
  modport sink(input valid, kind, node_a, node_b, weight, mask_bit, output ready);
endinterface

interface tedc_result_if import tedc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] node_count;
  logic               edge_taken;
  logic [TOTAL_W-1:0] taken_total;
  logic [TOTAL_W-1:0] seen_total;

  modport source(output valid, node_count, edge_taken, taken_total, seen_total, input ready);
  modport sink(input valid, node_count, edge_taken, taken_total, seen_total, output ready);
endinterface

// ===== rtl/core/tedc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tedc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tedc_regs.sv =====
// APB configuration registers of the degree counter.
`timescale 1ns / 1ps
module tedc_regs import tedc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [1:0] index;
  logic       wr_fire;

  assign index   = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_min  <= WEIGHT_MIN_RST;
      cfg.weight_max  <= WEIGHT_MAX_RST;
      cfg.mask_enable <= 1'b0;
    end else if (wr_fire) begin
      case (index)
        REG_WEIGHT_MIN:  cfg.weight_min  <= pwdata;
        REG_WEIGHT_MAX:  cfg.weight_max  <= pwdata;
        REG_MASK_ENABLE: cfg.mask_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_WEIGHT_MIN:  prdata = cfg.weight_min;
      REG_WEIGHT_MAX:  prdata = cfg.weight_max;
      REG_MASK_ENABLE: prdata = {{(CFG_DATA_W-1){1'b0}}, cfg.mask_enable};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tedc_ctrl.sv =====
// Sequencing state machine of the degree counter.
`timescale 1ns / 1ps
module tedc_ctrl import tedc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (stat.in_fire) begin
          state_next = ST_RD_A;
        end
      end
      ST_RD_A: begin
        state_next = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.cap_a  = 1'b1;
        cmd.rsel_b = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.cap_b  = 1'b1;
        state_next = ST_WR_A;
      end
      ST_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/tedc_dp.sv =====
// Datapath of the degree counter: request registers, memories, totals and result register.
`timescale 1ns / 1ps
module tedc_dp import tedc_pkg::*; #(
  parameter int NODE_COUNT = 65536,
  parameter int COUNT_BITS = 32
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  cmd_t   cmd,
  output stat_t  stat,
  tedc_item_if.sink     item,
  tedc_result_if.source result
);

  localparam int ADDR_W = $clog2(NODE_COUNT);
  localparam int IDX_W  = ((ADDR_W > NODE_W) ? ADDR_W : NODE_W) + 1;
  localparam logic [COUNT_BITS-1:0] CNT_ALL = '1;

  logic [KIND_W-1:0]     kind_q;
  logic [NODE_W-1:0]     a_q;
  logic [NODE_W-1:0]     b_q;
  logic                  mbit_q;
  logic                  a_ok_q;
  logic                  b_ok_q;
  logic                  w_ok_q;
  logic [COUNT_BITS-1:0] cnt_a_q;
  logic [COUNT_BITS-1:0] cnt_b_q;
  logic                  msk_a_q;
  logic                  msk_b_q;
  logic [ADDR_W-1:0]     clr_cnt;
  logic [TOTAL_W-1:0]    taken_edges;
  logic [TOTAL_W-1:0]    seen_edges;

  logic [ADDR_W-1:0]     addr_a;
  logic [ADDR_W-1:0]     addr_b;
  logic [ADDR_W-1:0]     raddr;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  msk_rd;
  logic                  cnt_we;
  logic [ADDR_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  msk_we;
  logic [ADDR_W-1:0]     msk_waddr;
  logic                  msk_wdata;
  logic                  is_edge;
  logic                  taken;
  logic [COUNT_BITS-1:0] inc_a;
  logic [COUNT_BITS-1:0] inc_b;
  logic [63:0]           cnt_wide;
  logic [TOTAL_W-1:0]    cnt_read;
  logic [TOTAL_W-1:0]    taken_next;
  logic [TOTAL_W-1:0]    seen_next;

  assign item.ready      = cmd.ready;
  assign stat.in_fire    = item.valid && cmd.ready;
  assign stat.clear_last = (clr_cnt == ADDR_W'(NODE_COUNT - 1));
  assign stat.out_busy   = result.valid && !result.ready;

  assign addr_a = ADDR_W'(a_q);
  assign addr_b = ADDR_W'(b_q);
  assign raddr  = cmd.rsel_b ? addr_b : addr_a;

  assign is_edge = (kind_q == KIND_EDGE);
  assign taken   = is_edge && a_ok_q && b_ok_q && w_ok_q &&
                   (!cfg.mask_enable || msk_a_q || msk_b_q);
  assign inc_a   = (cnt_a_q == CNT_ALL) ? cnt_a_q : cnt_a_q + COUNT_BITS'(1);
  assign inc_b   = (cnt_b_q == CNT_ALL) ? cnt_b_q : cnt_b_q + COUNT_BITS'(1);

  assign cnt_we    = cmd.clr || (cmd.wr_a && taken) || (cmd.fin && taken && (a_q != b_q));
  assign cnt_waddr = cmd.clr ? clr_cnt : (cmd.wr_a ? addr_a : addr_b);
  assign cnt_wdata = cmd.clr ? '0 : (cmd.wr_a ? inc_a : inc_b);

  assign msk_we    = cmd.clr || (cmd.fin && (kind_q == KIND_MASK) && a_ok_q);
  assign msk_waddr = cmd.clr ? clr_cnt : addr_a;
  assign msk_wdata = cmd.clr ? 1'b0 : mbit_q;

  assign cnt_wide = 64'(cnt_a_q);
  assign cnt_read = (cnt_wide > 64'hFFFF_FFFF) ? '1 : cnt_wide[TOTAL_W-1:0];

  assign seen_next  = (is_edge && (seen_edges != '1)) ? seen_edges + 1'b1 : seen_edges;
  assign taken_next = (taken && (taken_edges != '1)) ? taken_edges + 1'b1 : taken_edges;

  tedc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  tedc_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_msk_ram (
    .clk   (clk),
    .we    (msk_we),
    .waddr (msk_waddr),
    .wdata (msk_wdata),
    .raddr (raddr),
    .rdata (msk_rd)
  );

  always_ff @(posedge clk) begin
    if (stat.in_fire) begin
      kind_q <= item.kind;
      a_q    <= item.node_a;
      b_q    <= item.node_b;
      mbit_q <= item.mask_bit;
      a_ok_q <= IDX_W'(item.node_a) < IDX_W'(NODE_COUNT);
      b_ok_q <= IDX_W'(item.node_b) < IDX_W'(NODE_COUNT);
      w_ok_q <= (item.weight >= cfg.weight_min) && (item.weight <= cfg.weight_max);
    end
    if (cmd.cap_a) begin
      cnt_a_q <= cnt_rd;
      msk_a_q <= msk_rd;
    end
    if (cmd.cap_b) begin
      cnt_b_q <= cnt_rd;
      msk_b_q <= msk_rd;
    end
    if (cmd.fin) begin
      result.node_count  <= ((kind_q == KIND_READ) && a_ok_q) ? cnt_read : '0;
      result.edge_taken  <= taken;
      result.taken_total <= taken_next;
      result.seen_total  <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      taken_edges  <= '0;
      seen_edges   <= '0;
      result.valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.fin) begin
        taken_edges  <= taken_next;
        seen_edges   <= seen_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/thresholded_edge_degree_count.sv =====
// Each request steps through RD_A, RD_B, EVAL, WR_A and FIN to a valid result; the next
// request is accepted once back in IDLE, set by the read-read-write-write sequence on the
// count memory's one read port and one write port. A request is accepted while the previous
// result waits, but its last step stalls until that result is taken. After reset a clearing
// pass over every address zeroes both memories; requests wait, configuration writes do not.
// Top level of the thresholded edge degree counter.
`timescale 1ns / 1ps
module thresholded_edge_degree_count import tedc_pkg::*; #(
  parameter int NODE_COUNT = 65536,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  tedc_item_if.sink             item,
  tedc_result_if.source         result
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tedc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tedc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  tedc_dp #(.NODE_COUNT(NODE_COUNT), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat),
    .item   (item),
    .result (result)
  );

endmodule

// ===== rtl/core/tedc_checker.sv =====
// Port-level checker of the degree counter and its bind to the top level.
`timescale 1ns / 1ps
`include "thresholded_edge_degree_count_assert.svh"
module tedc_checker import tedc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [TOTAL_W-1:0] res_node_count,
  input logic               res_edge_taken,
  input logic [TOTAL_W-1:0] res_taken_total,
  input logic [TOTAL_W-1:0] res_seen_total
);

  `TEDC_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready must stay high")
  `TEDC_ASSERT(a_result_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_seen_total) && $stable(res_taken_total), "stalled result changed")
  `TEDC_ASSERT(a_taken_le_seen, clk, rst, res_valid |-> res_taken_total <= res_seen_total, "more edges taken than seen")
  `TEDC_ASSERT(a_taken_counted, clk, rst, res_valid && res_edge_taken |-> res_taken_total != '0, "taken edge missing from total")
  `TEDC_ASSERT(a_read_not_taken, clk, rst, res_valid && res_node_count != '0 |-> !res_edge_taken, "count read flagged as taken edge")

endmodule

bind thresholded_edge_degree_count tedc_checker u_tedc_checker (
  .clk             (clk),
  .rst             (rst),
  .pready          (pready),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .res_node_count  (result.node_count),
  .res_edge_taken  (result.edge_taken),
  .res_taken_total (result.taken_total),
  .res_seen_total  (result.seen_total)
);
